FILE: rtl/lrsw_pkg.sv
// Shared types and constants for the linked ring swap and walk engine.
package lrsw_pkg;

    localparam int OPCODE_W  = 3;
    localparam int IDX_W     = 10;
    localparam int RND_W     = 32;
    localparam int STEP_W    = 16;
    localparam int CNT_W     = 11;
    localparam int MIN_NODES = 6;

    localparam logic [OPCODE_W-1:0] OP_REBUILD  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SWAP     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SHUFFLE  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_WALK     = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SCRAMBLE = 3'd4;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

    // scramble hop counter: second entry after hop 3, next current after hop 6
    localparam logic [2:0] HOP_SECOND = 3'd2;
    localparam logic [2:0] HOP_LAST   = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SWEEP,
        S_DIV,
        S_RD_A,
        S_RD_B,
        S_DECIDE,
        S_F1R,
        S_F1W,
        S_F2R,
        S_F2W,
        S_F3R,
        S_F3W,
        S_F4R,
        S_F4W,
        S_F5,
        S_F6,
        S_J3,
        S_J4,
        S_WK_RD,
        S_WK_HOP,
        S_DONE
    } t_state;

endpackage

FILE: rtl/lrsw_if.sv
// Valid/ready channel interfaces for the input and result items.
interface lrsw_in_if;
    import lrsw_pkg::*;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [IDX_W-1:0]    index_a;
    logic [IDX_W-1:0]    index_b;
    logic [RND_W-1:0]    random_value;
    logic [STEP_W-1:0]   step_count;

    modport source (output valid, opcode, index_a, index_b, random_value, step_count,
                    input ready);
    modport sink   (input valid, opcode, index_a, index_b, random_value, step_count,
                    output ready);
endinterface

interface lrsw_out_if;
    import lrsw_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] node_index;
    logic             status;

    modport source (output valid, node_index, status, input ready);
    modport sink   (input valid, node_index, status, output ready);
endinterface

FILE: rtl/lrsw_ram.sv
// Generic single write port, single read port RAM with registered read.
module lrsw_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lrsw_mod.sv
// Bit-serial remainder unit: 32-bit word modulo the ring size, one bit per cycle.
module lrsw_mod #(
    parameter int NW = 11,
    parameter int AW = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lrsw_pkg::RND_W-1:0] i_dividend,
    input  logic [NW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [AW-1:0]              o_rem
);
    import lrsw_pkg::*;

    localparam int CW = $clog2(RND_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NW-1:0]    r_rem;
    logic [RND_W-1:0] r_dvd;
    logic [NW:0]      n_trial;
    logic [NW-1:0]    n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[RND_W-1]};
        if (n_trial >= {1'b0, i_divisor}) begin
            n_rem = NW'(n_trial - {1'b0, i_divisor});
        end else begin
            n_rem = NW'(n_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(RND_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            r_rem <= n_rem;
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = AW'(r_rem);

endmodule

FILE: rtl/linked_ring_swap_walk_engine.sv
// Top level of the linked ring swap and walk engine.
//
// Input items arrive on i_in (valid/ready), results leave on o_out through an
// output register; configuration is a single node_count register written by
// i_cfg_we/i_cfg_wdata; the user writes it only while the block is idle, which
// the block itself does not enforce. Ring links live in two RAMs (successor,
// predecessor) with a registered read; each write of a neighbour's link first
// reads the address it depends on, so it sees all earlier writes. One item is
// in work at a time; i_in.ready is high only while idle, so the next item is
// taken at the earliest the cycle after the result register loads.
// Paths from accept to result register:
//   out-of-range or unknown opcode, walk or scramble of zero steps: straight to done
//   a == b swap: both link reads, then done; adjacent swap: F1, F3, J3, J4; far swap: F1 to F6
//   shuffle: the remainder, then a swap; walk: one successor read per cycle
//   scramble walk: 6 chained reads plus a far swap per iteration; rebuild: one entry of both tables per cycle
// After reset the block sweeps both RAMs to the linear ring over
// min(1024, MAX_NODES) entries with i_in.ready low; configuration writes are
// taken during the sweep. A stalled o_out holds the finished item; a following
// result waits in its last state until the output register frees.
module linked_ring_swap_walk_engine #(
    parameter int MAX_NODES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lrsw_pkg::CNT_W-1:0] i_cfg_wdata,
    lrsw_in_if.sink                    i_in,
    lrsw_out_if.source                 o_out
);
    import lrsw_pkg::*;

    localparam int AW    = $clog2(MAX_NODES);
    localparam int NW    = $clog2(MAX_NODES + 1);
    localparam int KW    = (NW > CNT_W) ? NW : CNT_W;
    localparam int CW    = (NW > IDX_W) ? NW : IDX_W;
    localparam int N_RST = (MAX_NODES < int'(NODE_COUNT_RST)) ? MAX_NODES
                                                                : int'(NODE_COUNT_RST);

    t_state              r_state, n_state;
    logic                r_init, n_init;
    logic [OPCODE_W-1:0] r_op, n_op;
    logic [IDX_W-1:0]    r_res, n_res;
    logic                r_status, n_status;
    logic [NW-1:0]       r_n, n_n;
    logic [AW-1:0]       r_a, n_a;
    logic [AW-1:0]       r_b, n_b;
    logic [AW-1:0]       r_cur, n_cur;
    logic [AW-1:0]       r_pa, n_pa;
    logic [AW-1:0]       r_na, n_na;
    logic [AW-1:0]       r_pb, n_pb;
    logic [AW-1:0]       r_nb, n_nb;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic [2:0]          r_hop, n_hop;
    logic                r_far, n_far;
    logic [AW-1:0]       r_sw, n_sw;
    logic                r_out_valid, n_out_valid;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;
    logic                r_out_status, n_out_status;
    logic [CNT_W-1:0]    r_node_count;

    logic [NW-1:0] n_eff;
    logic          accept;
    logic          a_oor;
    logic          b_oor;

    logic          s_we, p_we;
    logic [AW-1:0] s_waddr, p_waddr;
    logic [AW-1:0] s_wdata, p_wdata;
    logic [AW-1:0] s_raddr, p_raddr;
    logic [AW-1:0] s_rdata, p_rdata;

    logic          mod_start;
    logic          mod_done;
    logic [AW-1:0] mod_rem;

    lrsw_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_succ_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    lrsw_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_pred_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    lrsw_mod #(.NW(NW), .AW(AW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_in.random_value),
        .i_divisor  (r_n),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_node_count < CNT_W'(MIN_NODES)) begin
            n_eff = NW'(MIN_NODES);
        end else if (KW'(r_node_count) > KW'(MAX_NODES)) begin
            n_eff = NW'(MAX_NODES);
        end else begin
            n_eff = NW'(r_node_count);
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign a_oor      = CW'(i_in.index_a) >= CW'(n_eff);
    assign b_oor      = CW'(i_in.index_b) >= CW'(n_eff);

    assign o_out.valid      = r_out_valid;
    assign o_out.node_index = r_out_idx;
    assign o_out.status     = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_init      <= 1'b1;
            r_n         <= NW'(N_RST);
            r_sw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_n         <= n_n;
            r_sw        <= n_sw;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_res        <= n_res;
        r_status     <= n_status;
        r_a          <= n_a;
        r_b          <= n_b;
        r_cur        <= n_cur;
        r_pa         <= n_pa;
        r_na         <= n_na;
        r_pb         <= n_pb;
        r_nb         <= n_nb;
        r_cnt        <= n_cnt;
        r_hop        <= n_hop;
        r_far        <= n_far;
        r_out_idx    <= n_out_idx;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_init       = r_init;
        n_op         = r_op;
        n_res        = r_res;
        n_status     = r_status;
        n_n          = r_n;
        n_a          = r_a;
        n_b          = r_b;
        n_cur        = r_cur;
        n_pa         = r_pa;
        n_na         = r_na;
        n_pb         = r_pb;
        n_nb         = r_nb;
        n_cnt        = r_cnt;
        n_hop        = r_hop;
        n_far        = r_far;
        n_sw         = r_sw;
        n_out_valid  = r_out_valid;
        n_out_idx    = r_out_idx;
        n_out_status = r_out_status;
        s_we         = 1'b0;
        p_we         = 1'b0;
        s_waddr      = '0;
        p_waddr      = '0;
        s_wdata      = '0;
        p_wdata      = '0;
        s_raddr      = '0;
        p_raddr      = '0;
        mod_start    = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = i_in.opcode;
                    n_res    = i_in.index_a;
                    n_status = ST_OK;
                    n_n      = n_eff;
                    n_a      = AW'(i_in.index_a);
                    n_b      = AW'(i_in.index_b);
                    n_cur    = AW'(i_in.index_a);
                    n_cnt    = i_in.step_count;
                    n_hop    = '0;
                    n_far    = 1'b1;
                    n_sw     = '0;
                    unique case (i_in.opcode) inside
                        OP_REBUILD: begin
                            n_state = S_SWEEP;
                        end
                        OP_SWAP: begin
                            if (a_oor || b_oor) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_RD_A;
                            end
                        end
                        OP_SHUFFLE: begin
                            if (a_oor) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                mod_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        OP_WALK, OP_SCRAMBLE: begin
                            if (a_oor) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else if (i_in.step_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_WK_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                s_we    = 1'b1;
                p_we    = 1'b1;
                s_waddr = r_sw;
                p_waddr = r_sw;
                if (NW'(r_sw) < r_n) begin
                    s_wdata = (NW'(r_sw) + NW'(1) == r_n) ? '0 : r_sw + AW'(1);
                    p_wdata = (r_sw == '0) ? AW'(r_n - NW'(1)) : r_sw - AW'(1);
                end else begin
                    s_wdata = r_sw;
                    p_wdata = r_sw;
                end
                n_sw = r_sw + AW'(1);
                if (r_sw == AW'(MAX_NODES - 1)) begin
                    n_sw    = '0;
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_DIV: begin
                if (mod_done) begin
                    n_b     = mod_rem;
                    n_state = S_RD_A;
                end
            end
            S_RD_A: begin
                s_raddr = r_a;
                p_raddr = r_a;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                n_pa    = p_rdata;
                n_na    = s_rdata;
                s_raddr = r_b;
                p_raddr = r_b;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_pb    = p_rdata;
                n_nb    = s_rdata;
                n_state = S_F1R;
                if (r_op != OP_SCRAMBLE) begin
                    if (r_pa == r_b) begin
                        // b directly precedes a
                        n_a   = r_b;
                        n_b   = r_a;
                        n_pa  = p_rdata;
                        n_nb  = r_na;
                        n_far = 1'b0;
                    end else if (r_na == r_b) begin
                        n_far = 1'b0;
                    end else if (r_a == r_b) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_F1R: begin
                p_raddr = r_a;
                n_state = S_F1W;
            end
            S_F1W: begin
                s_we    = 1'b1;
                s_waddr = p_rdata;
                s_wdata = r_b;
                n_state = r_far ? S_F2R : S_F3R;
            end
            S_F2R: begin
                s_raddr = r_a;
                n_state = S_F2W;
            end
            S_F2W: begin
                p_we    = 1'b1;
                p_waddr = s_rdata;
                p_wdata = r_b;
                n_state = S_F3R;
            end
            S_F3R: begin
                s_raddr = r_b;
                n_state = S_F3W;
            end
            S_F3W: begin
                p_we    = 1'b1;
                p_waddr = s_rdata;
                p_wdata = r_a;
                n_state = r_far ? S_F4R : S_J3;
            end
            S_F4R: begin
                p_raddr = r_b;
                n_state = S_F4W;
            end
            S_F4W: begin
                s_we    = 1'b1;
                s_waddr = p_rdata;
                s_wdata = r_a;
                n_state = S_F5;
            end
            S_F5: begin
                p_we    = 1'b1;
                p_waddr = r_a;
                p_wdata = r_pb;
                s_we    = 1'b1;
                s_waddr = r_a;
                s_wdata = r_nb;
                n_state = S_F6;
            end
            S_F6: begin
                s_we    = 1'b1;
                s_waddr = r_b;
                s_wdata = r_na;
                p_we    = 1'b1;
                p_waddr = r_b;
                p_wdata = r_pa;
                n_state = S_DONE;
                if (r_op == OP_SCRAMBLE) begin
                    if (r_cnt == STEP_W'(1)) begin
                        n_res = IDX_W'(r_cur);
                    end else begin
                        n_cnt   = r_cnt - STEP_W'(1);
                        n_a     = r_cur;
                        n_hop   = '0;
                        n_state = S_WK_RD;
                    end
                end
            end
            S_J3: begin
                p_we    = 1'b1;
                p_waddr = r_a;
                p_wdata = r_b;
                s_we    = 1'b1;
                s_waddr = r_a;
                s_wdata = r_nb;
                n_state = S_J4;
            end
            S_J4: begin
                s_we    = 1'b1;
                s_waddr = r_b;
                s_wdata = r_a;
                p_we    = 1'b1;
                p_waddr = r_b;
                p_wdata = r_pa;
                n_state = S_DONE;
            end
            S_WK_RD: begin
                s_raddr = (r_op == OP_SCRAMBLE) ? r_a : r_cur;
                n_state = S_WK_HOP;
            end
            S_WK_HOP: begin
                s_raddr = s_rdata;
                if (r_op == OP_SCRAMBLE) begin
                    if (r_hop == HOP_SECOND) begin
                        n_b = s_rdata;
                    end
                    if (r_hop == HOP_LAST) begin
                        n_cur   = s_rdata;
                        n_far   = 1'b1;
                        n_state = S_RD_A;
                    end else begin
                        n_hop = r_hop + 3'd1;
                    end
                end else begin
                    n_cur = s_rdata;
                    if (r_cnt == STEP_W'(1)) begin
                        n_res   = IDX_W'(s_rdata);
                        n_state = S_DONE;
                    end else begin
                        n_cnt = r_cnt - STEP_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = r_res;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_mod_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> r_state == S_DIV)
        else $error("remainder finished outside of shuffle wait");

    a_sweep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_SWEEP && r_state != S_SWEEP)
            |-> $past(r_sw) == AW'(MAX_NODES - 1))
        else $error("ring sweep left before the last entry");

    a_range_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_RANGE) |-> !s_we && !p_we)
        else $error("table written for an out-of-range item");

    a_hop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WK_HOP && r_op == OP_SCRAMBLE) |-> r_hop <= HOP_LAST)
        else $error("scramble hop counter overran");

    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_DONE && r_state == S_IDLE) |-> r_out_valid)
        else $error("item finished without loading the output register");

endmodule
